/* hdl/saturating_unsigned_alu_macros.svh */
// Assertion macros shared by the saturating unsigned ALU modules
`ifndef SATURATING_UNSIGNED_ALU_MACROS_SVH
`define SATURATING_UNSIGNED_ALU_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define SUA_ASSERT_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Delayed implication: pre implies post after the delay given by n, sampled on clk
`define SUA_ASSERT_DELAY(label, pre, post, n, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> ##n (post)) \
		else $error(msg);

`endif

/* hdl/sua_pkg.sv */
// Shared types and constants for the saturating unsigned ALU
package sua_pkg;

	localparam int unsigned DATA_WIDTH_DEF = 16;
	localparam int unsigned CMD_W          = 3;

	// Operation codes; the remaining codes give a zero result with no flags
	typedef enum logic [CMD_W-1:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_MOD = 3'd4
	} sua_cmd_t;

	// Control that travels alongside the data through the divider cells
	typedef struct packed {
		logic valid;
		logic is_div;
		logic is_mod;
		logic sat;
		logic dz;
	} sua_ctl_t;

endpackage

/* hdl/sua_front.sv */
// Input stage: add, subtract and multiply, then result and flag decode
module sua_front #(
	parameter int unsigned DATA_WIDTH = sua_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic [sua_pkg::CMD_W-1:0]    command,
	input  logic [DATA_WIDTH-1:0]        operand_a,
	input  logic [DATA_WIDTH-1:0]        operand_b,
	output sua_pkg::sua_ctl_t            ctl,
	output logic [DATA_WIDTH-1:0]        res,
	output logic [DATA_WIDTH-1:0]        dvd,
	output logic [DATA_WIDTH-1:0]        dsr
);

	logic                          valid_s1;
	logic [sua_pkg::CMD_W-1:0]     cmd_s1;
	logic [DATA_WIDTH-1:0]         a_s1;
	logic [DATA_WIDTH-1:0]         b_s1;
	logic [DATA_WIDTH:0]           sum_s1;
	logic [DATA_WIDTH:0]           diff_s1;
	logic [2*DATA_WIDTH-1:0]       prod_s1;
	logic                          b_zero;

	// Stage 1: raw arithmetic
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1  <= command;
		a_s1    <= operand_a;
		b_s1    <= operand_b;
		sum_s1  <= {1'b0, operand_a} + {1'b0, operand_b};
		diff_s1 <= {1'b0, operand_a} - {1'b0, operand_b};
		prod_s1 <= operand_a * operand_b;
	end

	assign b_zero = (b_s1 == '0);
	assign dvd    = a_s1;
	assign dsr    = b_s1;

	// Saturate, clamp and flag
	always_comb begin
		ctl        = '0;
		ctl.valid  = valid_s1;
		res        = '0;
		unique case (sua_pkg::sua_cmd_t'(cmd_s1))
			sua_pkg::CMD_ADD: begin
				ctl.sat = sum_s1[DATA_WIDTH];
				res     = sum_s1[DATA_WIDTH] ? '1 : sum_s1[DATA_WIDTH-1:0];
			end
			sua_pkg::CMD_SUB: begin
				// borrow out means a < b
				ctl.sat = diff_s1[DATA_WIDTH];
				res     = diff_s1[DATA_WIDTH] ? '0 : diff_s1[DATA_WIDTH-1:0];
			end
			sua_pkg::CMD_MUL: begin
				ctl.sat = |prod_s1[2*DATA_WIDTH-1:DATA_WIDTH];
				res     = ctl.sat ? '1 : prod_s1[DATA_WIDTH-1:0];
			end
			sua_pkg::CMD_DIV: begin
				ctl.is_div = 1'b1;
				ctl.dz     = b_zero;
			end
			sua_pkg::CMD_MOD: begin
				ctl.is_mod = 1'b1;
				ctl.dz     = b_zero;
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

/* hdl/sua_div_cell.sv */
// One restoring-division cell: settles one quotient bit per transaction
module sua_div_cell #(
	parameter int unsigned DATA_WIDTH = sua_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sua_pkg::sua_ctl_t     prev_ctl,
	input  logic [DATA_WIDTH-1:0] prev_res,
	input  logic [DATA_WIDTH-1:0] prev_rem,
	input  logic [DATA_WIDTH-1:0] prev_dvd,
	input  logic [DATA_WIDTH-1:0] prev_dsr,
	output sua_pkg::sua_ctl_t     next_ctl,
	output logic [DATA_WIDTH-1:0] next_res,
	output logic [DATA_WIDTH-1:0] next_rem,
	output logic [DATA_WIDTH-1:0] next_dvd,
	output logic [DATA_WIDTH-1:0] next_dsr
);

`include "saturating_unsigned_alu_macros.svh"

	sua_pkg::sua_ctl_t     ctl_q;
	logic [DATA_WIDTH-1:0] res_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] dvd_q;
	logic [DATA_WIDTH-1:0] dsr_q;
	logic [DATA_WIDTH:0]   trial;
	logic                  q_bit;
	logic [DATA_WIDTH-1:0] rem_n;

	// Shift in the next dividend bit and try the subtraction
	assign trial = {prev_rem, prev_dvd[DATA_WIDTH-1]} - {1'b0, prev_dsr};
	assign q_bit = ~trial[DATA_WIDTH];
	assign rem_n = q_bit ? trial[DATA_WIDTH-1:0]
	                     : {prev_rem[DATA_WIDTH-2:0], prev_dvd[DATA_WIDTH-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= prev_ctl;
		end
	end

	// Dividend register fills with quotient bits from the bottom
	always_ff @(posedge clk) begin
		res_q <= prev_res;
		rem_q <= rem_n;
		dvd_q <= {prev_dvd[DATA_WIDTH-2:0], q_bit};
		dsr_q <= prev_dsr;
	end

	assign next_ctl = ctl_q;
	assign next_res = res_q;
	assign next_rem = rem_q;
	assign next_dvd = dvd_q;
	assign next_dsr = dsr_q;

	`SUA_ASSERT_IMPLY(a_rem_below_dsr, ctl_q.valid && (dsr_q != '0), rem_q < dsr_q, "partial remainder not below divisor")

endmodule

/* hdl/saturating_unsigned_alu.sv */
// Top level of the saturating unsigned ALU: input stage, divider cell row, output register
//
// Saturating unsigned ALU. A transaction is taken on every clock edge where start is
// high; busy is never raised, so one transaction per cycle is sustained. Each
// transaction returns exactly one result, marked by done for one cycle, in the order
// taken; the receiver cannot hold results off and none are buffered. Each result
// passes through the row of DATA_WIDTH division cells, each of which settles one
// quotient bit, plus one input stage (add, subtract, the full-width multiply) and
// one output register. Add and multiply saturate at all ones,
// subtract clamps at zero, both raising saturated. Divide or modulo by zero raises
// divide_by_zero and gives all ones or the dividend respectively. Unused command codes
// give zero with no flags.
module saturating_unsigned_alu #(
	parameter int unsigned DATA_WIDTH = sua_pkg::DATA_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [sua_pkg::CMD_W-1:0] command,
	input  logic [DATA_WIDTH-1:0]     operand_a,
	input  logic [DATA_WIDTH-1:0]     operand_b,
	output logic                      done,
	output logic [DATA_WIDTH-1:0]     value,
	output logic                      saturated,
	output logic                      divide_by_zero
);

`include "saturating_unsigned_alu_macros.svh"

	localparam int unsigned LAT = DATA_WIDTH + 2;

	sua_pkg::sua_ctl_t     ctl_c [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] res_c [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] rem_c [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] dvd_c [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] dsr_c [0:DATA_WIDTH];
	sua_pkg::sua_ctl_t     last_ctl;

	logic                  done_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic                  sat_q;
	logic                  dz_q;

	// Every cycle can take a transaction
	assign busy = 1'b0;

	sua_front #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (start),
		.command  (command),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.ctl      (ctl_c[0]),
		.res      (res_c[0]),
		.dvd      (dvd_c[0]),
		.dsr      (dsr_c[0])
	);

	assign rem_c[0] = '0;

	// Division cell row, most significant quotient bit first
	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
		sua_div_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.prev_ctl(ctl_c[i]),
			.prev_res(res_c[i]),
			.prev_rem(rem_c[i]),
			.prev_dvd(dvd_c[i]),
			.prev_dsr(dsr_c[i]),
			.next_ctl(ctl_c[i+1]),
			.next_res(res_c[i+1]),
			.next_rem(rem_c[i+1]),
			.next_dvd(dvd_c[i+1]),
			.next_dsr(dsr_c[i+1])
		);
	end

	assign last_ctl = ctl_c[DATA_WIDTH];

	// Output register: quotient, remainder or the pre-computed result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		priority if (last_ctl.is_div) begin
			value_q <= dvd_c[DATA_WIDTH];
		end else if (last_ctl.is_mod) begin
			value_q <= rem_c[DATA_WIDTH];
		end else begin
			value_q <= res_c[DATA_WIDTH];
		end
		sat_q <= last_ctl.sat;
		dz_q  <= last_ctl.dz;
	end

	assign done           = done_q;
	assign value          = value_q;
	assign saturated      = sat_q;
	assign divide_by_zero = dz_q;

	`SUA_ASSERT_DELAY(a_latency, start, done, LAT, "result strobe missing after fixed latency")
	`SUA_ASSERT_IMPLY(a_flags_excl, done, !(saturated && divide_by_zero), "both flags set on one result")
	`SUA_ASSERT_IMPLY(a_sat_value, done && saturated, (value == '0) || (value == '1), "saturated result not at a rail")

endmodule
